[hdl/keyframe_linear_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_defines
// Assertion macros shared by the keyframe interpolator.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KLI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/kli_pkg.sv]
// ----------------------------------------------------------------------------
// kli_pkg
// Types and constants of the keyframe interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int DATA_W      = 32;
    localparam int KEY_COUNT_W = 5;
    localparam int WEIGHT_W    = 17;   // weight lies in [0, 65536]
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = 5;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [0:0] REG_KEY_COUNT    = 1'b0;
    localparam logic [0:0] REG_STATIC_VALUE = 1'b1;

    // query token walking down the cell chain
    typedef struct packed {
        logic              valid;
        logic              done;    // result already known, in res_v
        logic              found;   // enclosing segment latched
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] prev_t;  // entry of the upstream cell
        logic [DATA_W-1:0] prev_v;
        logic [DATA_W-1:0] res_v;
        logic [DATA_W-1:0] t0;
        logic [DATA_W-1:0] v0;
        logic [DATA_W-1:0] t1;
        logic [DATA_W-1:0] v1;
    } t_token;

endpackage

[hdl/kli_cell.sv]
// ----------------------------------------------------------------------------
// kli_cell
// One keyframe entry plus one stage of the query token chain.
// ----------------------------------------------------------------------------
module kli_cell import kli_pkg::*; #(
    parameter int K  = 0,
    parameter int CW = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic [DATA_W-1:0]        i_key_time,
    input  logic [DATA_W-1:0]        i_key_value,
    input  logic [CW-1:0]            i_n,
    input  t_token                   i_tok,
    output t_token                   o_tok
);

    localparam logic [CW-1:0] K_IDX  = CW'(K);
    localparam logic [CW-1:0] K_NEXT = CW'(K + 1);

    logic [DATA_W-1:0] r_time;
    logic [DATA_W-1:0] r_value;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_active;
    logic              w_last;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_time  <= i_key_time;
            r_value <= i_key_value;
        end
    end

    assign w_active = (K_IDX < i_n);
    assign w_last   = (K_NEXT == i_n);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.done && w_active) begin
            if (K == 0 && $signed(i_tok.t) <= $signed(r_time)) begin
                n_tok.done  = 1'b1;
                n_tok.res_v = r_value;
            end else if (w_last && $signed(i_tok.t) >= $signed(r_time)) begin
                n_tok.done  = 1'b1;
                n_tok.res_v = r_value;
            end else begin
                if (K != 0 && !i_tok.found &&
                    $signed(i_tok.prev_t) <= $signed(i_tok.t) &&
                    $signed(i_tok.t) <= $signed(r_time)) begin
                    n_tok.found = 1'b1;
                    n_tok.t0    = i_tok.prev_t;
                    n_tok.v0    = i_tok.prev_v;
                    n_tok.t1    = r_time;
                    n_tok.v1    = r_value;
                end
                // no segment anywhere: fall back to the last value
                if (w_last && !n_tok.found) begin
                    n_tok.done  = 1'b1;
                    n_tok.res_v = r_value;
                end
            end
        end
        n_tok.prev_t = r_time;
        n_tok.prev_v = r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[hdl/kli_divider.sv]
// ----------------------------------------------------------------------------
// kli_divider
// Restoring divider for the segment weight, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kli_divider import kli_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DATA_W-1:0]   i_num,   // t - t0, never above i_den
    input  logic [DATA_W-1:0]   i_den,   // t1 - t0
    output logic                o_done,
    output logic [WEIGHT_W-1:0] o_weight
);

    logic                 r_active;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W-1:0]    r_den;
    logic [WEIGHT_W-1:0]  r_q;
    logic                 w_ge;
    logic [DATA_W:0]      w_diff;

    assign w_ge   = (r_rem >= {1'b0, r_den});
    assign w_diff = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_active <= 1'b1;
                    r_cnt    <= DIV_CNT_W'(DIV_STEPS);
                end
            end else if (r_active) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_active) begin
            // remainder stays below the divisor, so the doubling fits
            r_rem <= {w_diff[DATA_W-1:0], 1'b0};
            r_q   <= {r_q[WEIGHT_W-2:0], w_ge};
        end
    end

    assign o_done   = r_done;
    assign o_weight = r_q;

endmodule

[hdl/keyframe_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Piecewise linear interpolation over a keyframe table held in a cell chain.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge with start high and busy low.
// i_command selects a load (writes entry i_key_index with i_key_time and
// i_key_value, no result, busy stays low) or a sample at i_sample_time.
// A sample raises busy; its result appears on o_sample_value for one cycle
// with o_sample_valid high. The receiver cannot stall the result.
// The query walks the chain of MAX_KEYS cells, one cell per cycle, which
// latches the enclosing segment or an end value. An end value or
// static_value is registered to the output as the token leaves the chain.
// When interpolating, the divider runs its 17 steps, the product is
// registered as the weight is taken, and the blend is then registered to
// the output. busy falls as the result is shown.
// APB registers: 0x0 key_count (counts above MAX_KEYS act as MAX_KEYS), 0x4 static_value.
// Reset clears both registers and the control state; table entries stay
// undefined until loaded.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_defines.svh"

module keyframe_linear_interpolator import kli_pkg::*; #(
    parameter int MAX_KEYS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [3:0]        i_key_index,
    input  logic [DATA_W-1:0] i_key_time,
    input  logic [DATA_W-1:0] i_key_value,
    input  logic [DATA_W-1:0] i_sample_time,
    output logic              o_sample_valid,
    output logic [DATA_W-1:0] o_sample_value,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int WW = (CW > KEY_COUNT_W) ? CW : KEY_COUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHAIN = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_MUL   = 2'd3;

    logic [KEY_COUNT_W-1:0] r_key_count;
    logic [DATA_W-1:0]      r_static_value;
    logic [1:0]             r_state;
    logic                   r_sample_valid;
    logic [DATA_W-1:0]      r_sample_value;
    logic [DATA_W-1:0]      r_v0;
    logic signed [DATA_W:0] r_dv;
    logic signed [50:0]     r_prod;

    logic [WW-1:0]          w_kc_ext;
    logic [CW-1:0]          w_n;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_sample;
    logic                   w_cfg_wr;
    t_token                 w_tok [0:MAX_KEYS];
    t_token                 w_end;
    logic [MAX_KEYS-1:0]    w_tok_valid;
    logic                   w_div_start;
    logic [DATA_W:0]        w_num;
    logic [DATA_W:0]        w_den;
    logic                   w_div_done;
    logic [WEIGHT_W-1:0]    w_weight;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count    <= '0;
            r_static_value <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_KEY_COUNT:    r_key_count    <= pwdata[KEY_COUNT_W-1:0];
                REG_STATIC_VALUE: r_static_value <= pwdata;
                default:          r_key_count    <= r_key_count;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KEY_COUNT:    prdata = {{(DATA_W-KEY_COUNT_W){1'b0}}, r_key_count};
            REG_STATIC_VALUE: prdata = r_static_value;
            default:          prdata = '0;
        endcase
    end

    assign w_kc_ext = WW'(r_key_count);
    assign w_n      = (w_kc_ext > WW'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(w_kc_ext);

    // ---------------- command channel ----------------
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_command == CMD_LOAD);
    assign w_sample = w_accept && (i_command == CMD_SAMPLE);

    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_sample;
        w_tok[0].done  = (w_n == '0);
        w_tok[0].res_v = r_static_value;
        w_tok[0].t     = i_sample_time;
    end

    // ---------------- cell chain ----------------
    for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
        kli_cell #(
            .K  (k),
            .CW (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (w_load && (32'(i_key_index) == k)),
            .i_key_time  (i_key_time),
            .i_key_value (i_key_value),
            .i_n         (w_n),
            .i_tok       (w_tok[k]),
            .o_tok       (w_tok[k+1])
        );
        assign w_tok_valid[k] = w_tok[k+1].valid;
    end

    assign w_end = w_tok[MAX_KEYS];

    // ---------------- weight and blend ----------------
    assign w_div_start = (r_state == ST_CHAIN) && w_end.valid && !w_end.done;
    assign w_num = {w_end.t[DATA_W-1], w_end.t} - {w_end.t0[DATA_W-1], w_end.t0};
    assign w_den = {w_end.t1[DATA_W-1], w_end.t1} - {w_end.t0[DATA_W-1], w_end.t0};

    kli_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_num[DATA_W-1:0]),
        .i_den    (w_den[DATA_W-1:0]),
        .o_done   (w_div_done),
        .o_weight (w_weight)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sample_valid <= 1'b0;
        end else begin
            r_sample_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_sample) begin
                        r_state <= ST_CHAIN;
                    end
                end
                ST_CHAIN: begin
                    if (w_end.valid) begin
                        if (w_end.done) begin
                            r_sample_valid <= 1'b1;
                            r_state        <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_sample_valid <= 1'b1;
                    r_state        <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_v0 <= w_end.v0;
            r_dv <= $signed({w_end.v1[DATA_W-1], w_end.v1})
                  - $signed({w_end.v0[DATA_W-1], w_end.v0});
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_prod <= $signed({1'b0, w_weight}) * r_dv;
        end
        if (r_state == ST_CHAIN && w_end.valid && w_end.done) begin
            r_sample_value <= w_end.res_v;
        end else if (r_state == ST_MUL) begin
            // arithmetic shift of the product floors toward minus infinity
            r_sample_value <= r_v0 + r_prod[47:16];
        end
    end

    assign o_sample_valid = r_sample_valid;
    assign o_sample_value = r_sample_value;

    // ---------------- assertions ----------------
    `KLI_ASSERT_NEXT(a_sample_sets_busy, i_clk, i_rst_n, w_sample, busy, "sample did not raise busy")
    `KLI_ASSERT_IMPL(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok_valid), "two query tokens in chain")
    `KLI_ASSERT_IMPL(a_token_in_chain_state, i_clk, i_rst_n, w_end.valid, r_state == ST_CHAIN, "token left chain outside chain state")
    `KLI_ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "weight ready outside divide state")

endmodule

[verif/tb_keyframe_linear_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolator
// Self-checking bench for the keyframe interpolator. Loads keyframe tables
// (sorted, with repeated times, and unsorted), programs key_count and
// static_value over APB between phases, and samples at key times, at range
// ends and inside segments. A scoreboard predicts each sample result and
// checks the result stream in order.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator;
    import kli_pkg::*;

    localparam int KEY_SLOTS   = 16;
    localparam int LAT_MAX     = KEY_SLOTS + 20;   // interpolating sample, accept to next accept
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 380;              // last phase runs past it, ~400 in all

    typedef struct {
        logic              cmd;
        logic [3:0]        idx;
        logic [DATA_W-1:0] ktime;
        logic [DATA_W-1:0] kvalue;
        logic [DATA_W-1:0] stime;
    } t_kf_txn;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the registers and the keyframe table
    // ------------------------------------------------------------------------
    class t_keyframe_checker;
        logic [KEY_COUNT_W-1:0]   key_count;
        logic signed [DATA_W-1:0] static_value;
        logic signed [DATA_W-1:0] key_time  [KEY_SLOTS];
        logic signed [DATA_W-1:0] key_value [KEY_SLOTS];
        logic [DATA_W-1:0]        pending_values [$];
        int                       fail_count;

        function void clear();
            key_count    = '0;
            static_value = '0;
            fail_count   = 0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                key_time[i]  = '0;
                key_value[i] = '0;
            end
            pending_values.delete();
        endfunction

        function void write_reg(logic [0:0] reg_idx, logic [DATA_W-1:0] data);
            if (reg_idx == REG_KEY_COUNT) key_count = data[KEY_COUNT_W-1:0];
            else static_value = data;
        endfunction

        function logic [DATA_W-1:0] interp_at(logic [DATA_W-1:0] t_q);
            int     n;
            int     i;
            longint t, t0, t1, v0, v1, w, r;
            n = (key_count > KEY_SLOTS) ? KEY_SLOTS : int'(key_count);
            t = longint'($signed(t_q));
            if (n == 0) return static_value;
            if (n == 1 || t <= longint'(key_time[0])) return key_value[0];
            if (t >= longint'(key_time[n-1])) return key_value[n-1];
            for (i = 0; i + 1 < n; i++) begin
                t0 = longint'(key_time[i]);
                t1 = longint'(key_time[i+1]);
                if (t >= t0 && t <= t1) begin
                    v0 = longint'(key_value[i]);
                    v1 = longint'(key_value[i+1]);
                    w  = (t1 > t0) ? ((t - t0) <<< 16) / (t1 - t0) : 0;
                    // arithmetic shift of a signed product rounds toward -inf
                    r  = v0 + ((w * (v1 - v0)) >>> 16);
                    return r[DATA_W-1:0];
                end
            end
            return key_value[n-1];
        endfunction

        function void note_transaction(t_kf_txn tr);
            if (tr.cmd == CMD_LOAD) begin
                key_time[tr.idx]  = tr.ktime;
                key_value[tr.idx] = tr.kvalue;
            end else begin
                pending_values = {pending_values, interp_at(tr.stime)};
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (pending_values.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected sample result %h", $realtime, got);
                return;
            end
            want = pending_values.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: sample_value mismatch: expected %h, got %h",
                             $realtime, want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_command = CMD_LOAD;
    logic [3:0]        i_key_index = '0;
    logic [DATA_W-1:0] i_key_time = '0;
    logic [DATA_W-1:0] i_key_value = '0;
    logic [DATA_W-1:0] i_sample_time = '0;
    logic              o_sample_valid;
    logic [DATA_W-1:0] o_sample_value;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_keyframe_checker chk;
    bit                idle_en = 1'b1;
    int                items_sent = 0;
    int                quiet_cycles = 0;

    keyframe_linear_interpolator #(
        .MAX_KEYS (KEY_SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_key_index    (i_key_index),
        .i_key_time     (i_key_time),
        .i_key_value    (i_key_value),
        .i_sample_time  (i_sample_time),
        .o_sample_valid (o_sample_valid),
        .o_sample_value (o_sample_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result monitor: a result is taken at the edge ending its valid cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_sample_valid) chk.check_result(o_sample_value);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_sample_valid || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** keyframe_linear_interpolator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_cmd(input t_kf_txn tr);
        int gap;
        if (idle_en && $urandom_range(99) < 22) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, LAT_MAX + 4)
                                           : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= tr.cmd;
        i_key_index   <= tr.idx;
        i_key_time    <= tr.ktime;
        i_key_value   <= tr.kvalue;
        i_sample_time <= tr.stime;
        do @(posedge i_clk); while (busy);
        chk.note_transaction(tr);
        items_sent++;
    endtask

    task automatic do_load(input logic [3:0] idx, input logic [DATA_W-1:0] kt,
                           input logic [DATA_W-1:0] kv);
        t_kf_txn tr;
        tr = '{CMD_LOAD, idx, kt, kv, $urandom};
        send_cmd(tr);
    endtask

    task automatic do_sample(input logic [DATA_W-1:0] st);
        t_kf_txn tr;
        tr = '{CMD_SAMPLE, 4'($urandom), $urandom, $urandom, st};
        send_cmd(tr);
    endtask

    // block idle: no result owed, then room for a load still in flight
    task automatic settle();
        start <= 1'b0;
        while (chk.pending_values.size() != 0 || busy) @(posedge i_clk);
        repeat (LAT_MAX + 4) @(posedge i_clk);
    endtask

    // psel is dropped before the task returns, which keeps back-to-back writes apart
    task automatic cfg_write(input logic [0:0] reg_idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chk.write_reg(reg_idx, data);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return DATA_W'(longint'($urandom_range(0, 2097152)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_time(int n);
        longint    a, b, lo, hi, pt;
        bit [63:0] r;
        int        sel;
        sel = $urandom_range(99);
        if (n == 0 || sel < 10) return $urandom;
        if (sel < 13) return 32'h8000_0000;
        if (sel < 16) return 32'h7FFF_FFFF;
        if (sel < 28) return chk.key_time[$urandom_range(0, n - 1)];
        a  = longint'(chk.key_time[0]);
        b  = longint'(chk.key_time[n-1]);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        r  = {$urandom, $urandom};
        pt = lo + longint'(r % 64'(hi - lo + 1));
        return pt[DATA_W-1:0];
    endfunction

    // fills entries 0..n-1: fine or coarse ascending times, or unordered
    task automatic load_table(input int n);
        int     mode;
        longint t, step_max;
        mode = $urandom_range(99);
        if (mode < 45) begin
            t        = longint'($urandom_range(0, 2097152)) - 1048576;
            step_max = 262144;
        end else begin
            t        = -longint'(32'h8000_0000) + longint'($urandom_range(0, 32'h0FFF_FFFF));
            step_max = 32'h0F00_0000;
        end
        for (int i = 0; i < n; i++) begin
            if (mode >= 80) t = longint'($signed(DATA_W'($urandom)));
            do_load(4'(i), t[DATA_W-1:0], pick_value());
            // repeated times now and then
            if ($urandom_range(7) != 0) t += longint'($urandom_range(0, 32'(step_max)));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int               p;
        int               kc;
        int               n;
        logic [DATA_W-1:0] waited;

        chk = new;
        chk.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no keyframes: static value, at both static extremes
        do_sample(32'h0000_0000);
        settle();
        cfg_write(REG_STATIC_VALUE, 32'h8000_0000);
        do_sample(32'h8000_0000);
        do_sample(32'h7FFF_FFFF);
        settle();
        cfg_write(REG_STATIC_VALUE, 32'h7FFF_FFFF);
        do_sample($urandom);

        // four keys spanning the whole time and value range
        do_load(4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        do_load(4'd1, 32'hFFFF_0000, 32'h8000_0000);
        do_load(4'd2, 32'h0001_0000, 32'h0000_0000);
        do_load(4'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        settle();
        cfg_write(REG_KEY_COUNT, 32'd4);
        do_sample(32'h8000_0000);
        do_sample(32'h8000_0001);
        do_sample(32'hC000_0000);
        do_sample(32'hFFFF_0000);
        do_sample(32'h0000_0000);
        do_sample(32'h0001_0000);
        do_sample(32'h7FFF_FFFE);
        do_sample(32'h7FFF_FFFF);
        settle();
        cfg_write(REG_KEY_COUNT, 32'd1);
        do_sample(32'h7FFF_FFFF);
        do_sample(32'h8000_0000);
        settle();
        cfg_write(REG_KEY_COUNT, 32'd2);
        do_sample(32'h0000_0000);

        // random phases; the first loads the whole table
        p = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            case (p)
                0:       kc = KEY_SLOTS;
                1:       kc = 31;          // saturates to a full table
                2:       kc = KEY_SLOTS + 1;
                3:       kc = 0;
                4:       kc = 1;
                5:       kc = 2;
                default: kc = ($urandom_range(3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(2, KEY_SLOTS);
            endcase
            cfg_write(REG_KEY_COUNT, 32'(kc));
            cfg_write(REG_STATIC_VALUE, pick_value());
            idle_en = (p != 6);
            n = (kc > KEY_SLOTS) ? KEY_SLOTS : kc;
            load_table(n);
            repeat (30) begin
                if ($urandom_range(99) < 8) do_load(4'($urandom), $urandom, pick_value());
                else do_sample(pick_time(n));
            end
            p++;
        end

        start <= 1'b0;
        waited = '0;
        while (chk.pending_values.size() != 0 && waited < 32'(4 * LAT_MAX)) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LAT_MAX + 4) @(posedge i_clk);
        if (chk.pending_values.size() != 0) begin
            $display("%0d sample results never arrived", chk.pending_values.size());
            chk.fail_count += chk.pending_values.size();
        end

        if (chk.fail_count == 0) begin
            $display("** keyframe_linear_interpolator: PASSED **");
        end else begin
            $display("** keyframe_linear_interpolator: FAILED **");
        end
        $finish;
    end

endmodule
